// ----- design/assert_macros.svh -----
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT_RST(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT(label, clk_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/pml_pkg.sv -----
`timescale 1ns / 1ps

package pml_pkg;

  localparam int MAX_DIMS = 4;
  localparam int DIMS     = 4;
  localparam int CFG_AW   = 5;

  typedef enum logic [2:0] {
    REG_ENABLE = 3'd0,
    REG_MASK   = 3'd1,
    REG_PLEN0  = 3'd2,
    REG_PLEN1  = 3'd3,
    REG_PLEN2  = 3'd4,
    REG_PLEN3  = 3'd5
  } reg_idx_t;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t x_0;
    coord_t x_1;
    coord_t x_2;
    coord_t x_3;
    coord_t y_0;
    coord_t y_1;
    coord_t y_2;
    coord_t y_3;
  } in_t;

  typedef struct packed {
    coord_t      lifted_0;
    coord_t      lifted_1;
    coord_t      lifted_2;
    coord_t      lifted_3;
    logic [63:0] distance_squared;
  } out_t;

  typedef struct packed {
    logic                         enable;
    logic [MAX_DIMS-1:0]          mask;
    logic [MAX_DIMS-1:0][30:0]    period;
  } cfg_t;

  // Per-lane choice handed from the lift stages to the distance stages.
  typedef struct packed {
    coord_t [MAX_DIMS-1:0]        best;
    logic [MAX_DIMS-1:0][31:0]    delta;
  } lane_t;

  function automatic coord_t sat32(input logic signed [33:0] v);
    if (v[33:31] != {3{v[33]}}) begin
      return v[33] ? coord_t'({1'b1, 31'h0}) : coord_t'({1'b0, {31{1'b1}}});
    end
    return coord_t'(v[31:0]);
  endfunction

  function automatic logic [31:0] absdiff(input coord_t a, input coord_t b);
    logic signed [32:0] diff;
    logic [32:0]        neg;
    diff = {a[31], a} - {b[31], b};
    neg  = -diff;
    return diff[32] ? neg[31:0] : diff[31:0];
  endfunction

endpackage

// ----- design/pml_cfg.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pml_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pml_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output pml_pkg::cfg_t              cfg
);
  import pml_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_ENABLE: cfg_nxt.enable    = pwdata[0];
        REG_MASK:   cfg_nxt.mask      = pwdata[MAX_DIMS-1:0];
        REG_PLEN0:  cfg_nxt.period[0] = pwdata[30:0];
        REG_PLEN1:  cfg_nxt.period[1] = pwdata[30:0];
        REG_PLEN2:  cfg_nxt.period[2] = pwdata[30:0];
        REG_PLEN3:  cfg_nxt.period[3] = pwdata[30:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLE: prdata = {31'b0, cfg_r.enable};
      REG_MASK:   prdata = {{(32-MAX_DIMS){1'b0}}, cfg_r.mask};
      REG_PLEN0:  prdata = {1'b0, cfg_r.period[0]};
      REG_PLEN1:  prdata = {1'b0, cfg_r.period[1]};
      REG_PLEN2:  prdata = {1'b0, cfg_r.period[2]};
      REG_PLEN3:  prdata = {1'b0, cfg_r.period[3]};
      default:    prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  `ASSERT_NEXT(a_reset_clears_cfg, clk, !rst_n, cfg_r == '0, "configuration not cleared by reset")

endmodule

// ----- design/pml_lift.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pml_lift (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  pml_pkg::cfg_t   cfg,
  input  logic            in_valid,
  input  pml_pkg::in_t    in_data,
  output logic            lane_valid,
  output pml_pkg::lane_t  lane
);
  import pml_pkg::*;

  coord_t [MAX_DIMS-1:0] x_in;
  coord_t [MAX_DIMS-1:0] y_in;

  // Stage 1: shifted candidates, saturated.
  logic                         s1_valid_r;
  coord_t [MAX_DIMS-1:0]        s1_x_r, s1_y_r, s1_cm_r, s1_cp_r;
  coord_t [MAX_DIMS-1:0]        s1_cm_nxt, s1_cp_nxt;
  logic [MAX_DIMS-1:0]          s1_en_r, s1_en_nxt;

  // Stage 2: distances of the three candidates to x.
  logic                         s2_valid_r;
  coord_t [MAX_DIMS-1:0]        s2_y_r, s2_cm_r, s2_cp_r;
  logic [MAX_DIMS-1:0][31:0]    s2_do_r, s2_dm_r, s2_dp_r;
  logic [MAX_DIMS-1:0][31:0]    s2_do_nxt, s2_dm_nxt, s2_dp_nxt;
  logic [MAX_DIMS-1:0]          s2_en_r;

  // Stage 3: the chosen image and its distance.
  logic                         s3_valid_r;
  lane_t                        lane_r, lane_nxt;

  assign x_in[0] = in_data.x_0;
  assign x_in[1] = in_data.x_1;
  assign x_in[2] = in_data.x_2;
  assign x_in[3] = in_data.x_3;
  assign y_in[0] = in_data.y_0;
  assign y_in[1] = in_data.y_1;
  assign y_in[2] = in_data.y_2;
  assign y_in[3] = in_data.y_3;

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      s1_cm_nxt[d] = sat32({y_in[d][31], y_in[d][31], y_in[d]} - {3'b000, cfg.period[d]});
      s1_cp_nxt[d] = sat32({y_in[d][31], y_in[d][31], y_in[d]} + {3'b000, cfg.period[d]});
      s1_en_nxt[d] = (d < DIMS) && cfg.enable && cfg.mask[d];
    end
  end

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      s2_do_nxt[d] = absdiff(s1_x_r[d], s1_y_r[d]);
      s2_dm_nxt[d] = absdiff(s1_x_r[d], s1_cm_r[d]);
      s2_dp_nxt[d] = absdiff(s1_x_r[d], s1_cp_r[d]);
    end
  end

  // The original point keeps any tie; the minus image beats the plus image on a tie.
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      lane_nxt.best[d]  = s2_y_r[d];
      lane_nxt.delta[d] = s2_do_r[d];
      if (s2_en_r[d] && (s2_dm_r[d] < lane_nxt.delta[d])) begin
        lane_nxt.best[d]  = s2_cm_r[d];
        lane_nxt.delta[d] = s2_dm_r[d];
      end
      if (s2_en_r[d] && (s2_dp_r[d] < lane_nxt.delta[d])) begin
        lane_nxt.best[d]  = s2_cp_r[d];
        lane_nxt.delta[d] = s2_dp_r[d];
      end
      if (d >= DIMS) begin
        lane_nxt.best[d]  = '0;
        lane_nxt.delta[d] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x_r  <= x_in;
      s1_y_r  <= y_in;
      s1_cm_r <= s1_cm_nxt;
      s1_cp_r <= s1_cp_nxt;
      s1_en_r <= s1_en_nxt;
      s2_y_r  <= s1_y_r;
      s2_cm_r <= s1_cm_r;
      s2_cp_r <= s1_cp_r;
      s2_en_r <= s1_en_r;
      s2_do_r <= s2_do_nxt;
      s2_dm_r <= s2_dm_nxt;
      s2_dp_r <= s2_dp_nxt;
      lane_r  <= lane_nxt;
    end
  end

  assign lane_valid = s3_valid_r;
  assign lane       = lane_r;

  `ASSERT_NEXT_RST(a_plain_lane_keeps_y, clk, rst_n, adv && s2_valid_r && !s2_en_r[0], lane_r.best[0] == $past(s2_y_r[0]), "unlifted coordinate changed")

endmodule

// ----- design/pml_dist.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pml_dist (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            lane_valid,
  input  pml_pkg::lane_t  lane,
  output logic            out_valid,
  output pml_pkg::out_t   out_data
);
  import pml_pkg::*;

  localparam int HALF = MAX_DIMS / 2;

  // Stage 4: one multiplier per coordinate.
  logic                       s4_valid_r;
  coord_t [MAX_DIMS-1:0]      s4_best_r;
  logic [MAX_DIMS-1:0][63:0]  s4_sq_r, s4_sq_nxt;

  // Stage 5: pairwise sums.
  logic                       s5_valid_r;
  coord_t [MAX_DIMS-1:0]      s5_best_r;
  logic [HALF-1:0][64:0]      s5_pair_r, s5_pair_nxt;

  // Stage 6: final sum, floored to Q48.16.
  logic                       s6_valid_r;
  out_t                       out_r, out_nxt;
  logic [65:0]                total;

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      s4_sq_nxt[d] = 64'(lane.delta[d]) * 64'(lane.delta[d]);
    end
  end

  always_comb begin
    for (int k = 0; k < HALF; k++) begin
      s5_pair_nxt[k] = {1'b0, s4_sq_r[2*k]} + {1'b0, s4_sq_r[2*k+1]};
    end
  end

  assign total = {1'b0, s5_pair_r[0]} + {1'b0, s5_pair_r[1]};

  always_comb begin
    out_nxt.lifted_0         = s5_best_r[0];
    out_nxt.lifted_1         = s5_best_r[1];
    out_nxt.lifted_2         = s5_best_r[2];
    out_nxt.lifted_3         = s5_best_r[3];
    out_nxt.distance_squared = {14'b0, total[65:16]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= lane_valid;
      s5_valid_r <= s4_valid_r;
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_best_r <= lane.best;
      s4_sq_r   <= s4_sq_nxt;
      s5_best_r <= s4_best_r;
      s5_pair_r <= s5_pair_nxt;
      out_r     <= out_nxt;
    end
  end

  assign out_valid = s6_valid_r;
  assign out_data  = out_r;

  `ASSERT_IMPLY(a_distance_in_range, clk, rst_n, out_valid, out_data.distance_squared[63:50] == '0, "distance above its reachable range")

endmodule

// ----- design/periodic_minimum_image_lift.sv -----
// Throughput: one beat per cycle; four lane multipliers and a two-level adder
// tree each take a full stage, and the whole pipe holds while a result beat waits.
// Reset: synchronous, active-low rst_n clears all stage valid bits and sets every
// configuration register to zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module periodic_minimum_image_lift (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  pml_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output pml_pkg::out_t              out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pml_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import pml_pkg::*;

  cfg_t  cfg;
  logic  adv;
  logic  lane_valid;
  lane_t lane;

  // Every stage moves on together unless a finished beat is being held.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  pml_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pml_lift u_lift (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .lane_valid (lane_valid),
    .lane       (lane)
  );

  pml_dist u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .lane_valid (lane_valid),
    .lane       (lane),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  `ASSERT_IMPLY(a_stall_only_when_full, clk, rst_n, in_stall, out_valid, "input stalled with no result waiting")

endmodule

// ----- dv/tb_periodic_minimum_image_lift.sv -----
`timescale 1ns / 1ps

module tb_periodic_minimum_image_lift;
  import pml_pkg::*;

  localparam int PIPE_LAT    = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 2000;
  localparam int PHASES      = 10;
  localparam int PHASE_BEATS = 75;

  // Addresses beyond the last register; writes there must change nothing.
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  localparam coord_t Q_MAX  = 32'sh7FFF_FFFF;
  localparam coord_t Q_MIN  = 32'sh8000_0000;
  localparam coord_t Q_ONE  = 32'sh0001_0000;
  localparam coord_t Q_FIVE = 32'sh0005_0000;
  localparam coord_t Q_SIX  = 32'sh0006_0000;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [31:0] val;
    logic        known;
    in_t         beat;
    out_t        want;
  } row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_t                 in_data;
  logic                out_valid;
  logic                out_stall;
  out_t                out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  cfg_t cfg_shadow = '0;
  out_t pending_points[$];
  int   mismatches   = 0;
  int   stuck_cycles = 0;
  int   holds_asked  = 0;
  int   holds_done   = 0;
  int   hold_left    = 0;
  bit   quiet        = 1'b0;

  periodic_minimum_image_lift dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic coord_t clamp_q16(input longint signed v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return coord_t'(v);
  endfunction

  function automatic longint unsigned gap(input longint signed a, input longint signed b);
    return (a >= b) ? longint'(a - b) : longint'(b - a);
  endfunction

  // Each periodic lane picks the closest of y, y - P and y + P; y keeps ties and the
  // lower image beats the upper one. Squares are summed in Q32.32 and floored to Q48.16.
  function automatic out_t lift_toward(input in_t p);
    coord_t            xs[4];
    coord_t            ys[4];
    coord_t            best[4];
    coord_t            lo_c;
    coord_t            hi_c;
    longint signed     per;
    longint unsigned   bd;
    longint unsigned   d_lo;
    longint unsigned   d_hi;
    longint unsigned   sq;
    longint unsigned   acc_hi;
    longint unsigned   acc_lo;
    out_t              r;
    int                d;
    xs = '{p.x_0, p.x_1, p.x_2, p.x_3};
    ys = '{p.y_0, p.y_1, p.y_2, p.y_3};
    acc_hi = 0;
    acc_lo = 0;
    for (d = 0; d < 4; d++) begin
      if (d >= DIMS) begin
        best[d] = '0;
        continue;
      end
      best[d] = ys[d];
      bd = gap(xs[d], ys[d]);
      if (cfg_shadow.enable && cfg_shadow.mask[d]) begin
        per  = longint'(cfg_shadow.period[d]);
        lo_c = clamp_q16(ys[d] - per);
        hi_c = clamp_q16(ys[d] + per);
        d_lo = gap(xs[d], lo_c);
        d_hi = gap(xs[d], hi_c);
        if (d_lo < bd) begin
          bd = d_lo;
          best[d] = lo_c;
        end
        if (d_hi < bd) begin
          bd = d_hi;
          best[d] = hi_c;
        end
      end
      sq = bd * bd;
      acc_hi += sq >> 16;
      acc_lo += sq[15:0];
    end
    r.lifted_0 = best[0];
    r.lifted_1 = best[1];
    r.lifted_2 = best[2];
    r.lifted_3 = best[3];
    r.distance_squared = acc_hi + (acc_lo >> 16);
    return r;
  endfunction

  function automatic in_t beat_on(input logic [3:0] lanes, input coord_t x, input coord_t y);
    in_t b;
    b = '0;
    if (lanes[0]) begin
      b.x_0 = x;
      b.y_0 = y;
    end
    if (lanes[1]) begin
      b.x_1 = x;
      b.y_1 = y;
    end
    if (lanes[2]) begin
      b.x_2 = x;
      b.y_2 = y;
    end
    if (lanes[3]) begin
      b.x_3 = x;
      b.y_3 = y;
    end
    return b;
  endfunction

  function automatic out_t want_of(input logic [3:0] lanes, input coord_t lifted,
                                   input logic [63:0] dsq);
    out_t r;
    r = '0;
    if (lanes[0]) r.lifted_0 = lifted;
    if (lanes[1]) r.lifted_1 = lifted;
    if (lanes[2]) r.lifted_2 = lifted;
    if (lanes[3]) r.lifted_3 = lifted;
    r.distance_squared = dsq;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [2:0] idx, input logic [31:0] v);
    row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.val  = v;
    return r;
  endfunction

  function automatic row_t beat_row(input in_t b);
    row_t r;
    r = '0;
    r.kind = ROW_BEAT;
    r.beat = b;
    return r;
  endfunction

  function automatic row_t known_row(input in_t b, input out_t w);
    row_t r;
    r = beat_row(b);
    r.known = 1'b1;
    r.want  = w;
    return r;
  endfunction

  function automatic coord_t rail_value();
    case ($urandom_range(0, 5))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return '0;
      3: return coord_t'(-1);
      4: return Q_MIN + 1;
      default: return Q_MAX - 1;
    endcase
  endfunction

  // Most lanes put y within a period and a half of x so that both images get picked;
  // the rest is raw noise, rail values and offsets of half a period or one and a half periods.
  function automatic in_t rand_beat();
    coord_t          xs[4];
    coord_t          ys[4];
    longint signed   per;
    longint signed   xv;
    longint signed   yv;
    longint signed   half;
    longint unsigned span;
    longint unsigned r64;
    int              d;
    for (d = 0; d < 4; d++) begin
      per = longint'(cfg_shadow.period[d]);
      xv  = coord_t'($urandom) >>> $urandom_range(0, 16);
      case ($urandom_range(0, 9))
        0, 1: begin
          xv = coord_t'($urandom);
          yv = coord_t'($urandom);
        end
        2: begin
          xv = rail_value();
          yv = rail_value();
        end
        3: begin
          half = per / 2 + $urandom_range(0, 1) * per;
          yv = $urandom_range(0, 1) ? xv + half : xv - half;
        end
        default: begin
          if (per == 0) begin
            yv = xv + longint'($urandom_range(0, 2000)) - 1000;
          end else begin
            span = 3 * per + 1;
            r64  = {$urandom, $urandom};
            yv   = xv + longint'(r64 % span) - (3 * per) / 2;
          end
        end
      endcase
      xs[d] = clamp_q16(xv);
      ys[d] = clamp_q16(yv);
    end
    return '{x_0: xs[0], x_1: xs[1], x_2: xs[2], x_3: xs[3],
             y_0: ys[0], y_1: ys[1], y_2: ys[2], y_3: ys[3]};
  endfunction

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ENABLE: cfg_shadow.enable = v[0];
      REG_MASK:   cfg_shadow.mask   = v[3:0];
      REG_PLEN0, REG_PLEN1, REG_PLEN2, REG_PLEN3:
        cfg_shadow.period[idx - REG_PLEN0] = v[30:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Returns in the cycle of acceptance with valid still high, so the caller either
  // offers the next beat or lowers valid in that same cycle.
  task automatic send_beat(input in_t b, input logic known, input out_t want);
    while (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    pending_points.push_back(known ? want : lift_toward(b));
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_t head;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, actual %h", $time, out_data);
      end else begin
        head = pending_points.pop_front();
        check_field("lifted_0", head.lifted_0, out_data.lifted_0);
        check_field("lifted_1", head.lifted_1, out_data.lifted_1);
        check_field("lifted_2", head.lifted_2, out_data.lifted_2);
        check_field("lifted_3", head.lifted_3, out_data.lifted_3);
        check_field("distance_squared", head.distance_squared, out_data.distance_squared);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_stall <= 1'b0;
      end else if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (holds_done < holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 7);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    row_t        rows[$];
    logic [31:0] word;
    int          ph;
    int          i;
    int          d;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Straight after reset nothing is periodic.
    rows.push_back(known_row(beat_on(4'b1111, 0, 0), want_of(4'b1111, 0, 0)));
    rows.push_back(known_row(beat_on(4'b0001, Q_ONE, 0), want_of(4'b0001, 0, 64'h1_0000)));
    rows.push_back(beat_row(beat_on(4'b1111, Q_MIN, Q_MAX)));
    rows.push_back(beat_row(beat_on(4'b1111, Q_MAX, Q_MIN)));
    rows.push_back(beat_row(beat_on(4'b1111, 32'sh5555_5555, 32'shAAAA_AAAA)));
    // All ones everywhere: only the register width may survive.
    rows.push_back(cfg_row(REG_ENABLE, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(REG_MASK, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(REG_PLEN0, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(REG_PLEN1, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(REG_PLEN2, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(REG_PLEN3, 32'hFFFF_FFFF));
    rows.push_back(beat_row(beat_on(4'b1111, Q_MIN, Q_MAX)));
    rows.push_back(beat_row(beat_on(4'b1111, Q_MAX, Q_MIN)));
    // Saturated images collapse onto y, and y keeps the tie.
    rows.push_back(known_row(beat_on(4'b1111, Q_MAX, Q_MAX), want_of(4'b1111, Q_MAX, 0)));
    rows.push_back(known_row(beat_on(4'b1111, Q_MIN, Q_MIN), want_of(4'b1111, Q_MIN, 0)));
    // A period of 10.0 on every lane.
    rows.push_back(cfg_row(REG_PLEN0, 32'h000A_0000));
    rows.push_back(cfg_row(REG_PLEN1, 32'h000A_0000));
    rows.push_back(cfg_row(REG_PLEN2, 32'h000A_0000));
    rows.push_back(cfg_row(REG_PLEN3, 32'h000A_0000));
    rows.push_back(known_row(beat_on(4'b0001, 0, Q_FIVE),
                             want_of(4'b0001, Q_FIVE, 64'h19_0000)));
    rows.push_back(known_row(beat_on(4'b0010, 0, -Q_FIVE),
                             want_of(4'b0010, -Q_FIVE, 64'h19_0000)));
    rows.push_back(known_row(beat_on(4'b0100, -Q_FIVE, Q_FIVE), want_of(4'b0100, -Q_FIVE, 0)));
    rows.push_back(known_row(beat_on(4'b1000, 0, Q_SIX),
                             want_of(4'b1000, coord_t'(32'shFFFC_0000), 64'h10_0000)));
    rows.push_back(known_row(beat_on(4'b0001, Q_FIVE, -Q_FIVE), want_of(4'b0001, Q_FIVE, 0)));
    rows.push_back(beat_row(beat_on(4'b1111, 32'sh7FFF_0000, 32'sh8001_0000)));
    // Partial mask, and a zero period on lane 1.
    rows.push_back(cfg_row(REG_MASK, 32'h0000_0005));
    rows.push_back(cfg_row(REG_PLEN1, 32'h0000_0000));
    rows.push_back(beat_row(beat_on(4'b1111, 0, Q_SIX)));
    rows.push_back(cfg_row(REG_MASK, 32'h0000_000F));
    rows.push_back(known_row(beat_on(4'b0010, 0, Q_SIX), want_of(4'b0010, Q_SIX, 64'h24_0000)));
    rows.push_back(cfg_row(REG_ENABLE, 32'h0000_0000));
    rows.push_back(known_row(beat_on(4'b0001, 0, Q_SIX), want_of(4'b0001, Q_SIX, 64'h24_0000)));
    rows.push_back(cfg_row(REG_SPARE_A, 32'hFFFF_FFFF));
    rows.push_back(cfg_row(REG_SPARE_B, 32'hFFFF_FFFF));
    rows.push_back(beat_row(beat_on(4'b1111, 0, Q_SIX)));
    rows.push_back(cfg_row(REG_ENABLE, 32'h0000_0001));
    rows.push_back(beat_row(beat_on(4'b1111, 0, Q_SIX)));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        send_beat(rows[i].beat, rows[i].known, rows[i].want);
      end
    end

    // Random phases: the first has every period at its maximum, the second all zero.
    for (ph = 0; ph < PHASES; ph++) begin
      word = $urandom;
      word[0] = (ph != 1) && ($urandom_range(0, 3) != 0);
      write_reg(REG_ENABLE, word);
      write_reg(REG_MASK, (ph == 0) ? 32'hFFFF_FFFF : $urandom);
      for (d = 0; d < 4; d++) begin
        if (ph == 0) begin
          word = 32'h7FFF_FFFF;
        end else if (ph == 1) begin
          word = '0;
        end else begin
          case ($urandom_range(0, 3))
            0: word = '0;
            1: word = {1'($urandom_range(0, 1)), 31'h7FFF_FFFF};
            2: word = $urandom_range(1, 32'h0010_0000);
            default: word = $urandom;
          endcase
        end
        write_reg(REG_PLEN0 + 3'(d), word);
      end
      if (ph == 7) write_reg(REG_SPARE_A, $urandom);
      quiet = (ph == 6);
      if (ph == 3) holds_asked++;
      for (i = 0; i < PHASE_BEATS; i++) begin
        if (ph == 5 && i == PHASE_BEATS / 2) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (pending_points.size() != 0);
        end
        send_beat(rand_beat(), 1'b0, '0);
      end
    end
    quiet = 1'b0;

    settle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
